// ===== src/hga_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hash group aggregator.
// No dependencies; used by every module under src but hga_ram.
package hga_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int unsigned CPU_SHIFT = 24;
  localparam int unsigned FLAGS_SHIFT = 12;
  localparam int unsigned SKIP_BIT = 4;

  typedef enum logic [2:0] {
    STAT_NEW      = 3'd0,
    STAT_HIT      = 3'd1,
    STAT_SKIP     = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_RD_USED  = 3'd4,
    STAT_RD_EMPTY = 3'd5
  } hga_status_e;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SKIP   = 2'd1,
    CMD_READ   = 2'd2
  } hga_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_CHECK = 2'd2
  } hga_state_e;

  // Classified request; home is the unmasked hash, the back end masks it.
  typedef struct packed {
    hga_kind_e   kind;
    logic [63:0] seq;
    logic [31:0] frame;
    logic [31:0] pc;
    logic [31:0] op_sig;
    logic [31:0] raw;
    logic [31:0] value;
    logic [15:0] slot;
    logic [23:0] attrs;
    logic [11:0] read_index;
    logic [31:0] home;
  } hga_cmd_t;

  typedef struct packed {
    logic        used;
    logic [31:0] pc;
    logic [31:0] op_sig;
    logic [23:0] attrs;
    logic [63:0] count;
    logic [63:0] start_seq;
    logic [31:0] start_frame;
    logic [31:0] latest_frame;
    logic [31:0] raw_sample;
    logic [31:0] value_sample;
    logic [15:0] slot_lo;
    logic [15:0] slot_hi;
  } hga_entry_t;

  typedef struct packed {
    hga_status_e status;
    logic [11:0] entry_index;
    logic [31:0] group_pc;
    logic [31:0] group_opcode_hash;
    logic [23:0] group_attrs;
    logic [63:0] group_count;
    logic [63:0] group_first_seq;
    logic [31:0] group_first_frame;
    logic [31:0] group_last_frame;
    logic [31:0] group_sample_raw;
    logic [31:0] group_sample_value;
    logic [31:0] group_slot_span;
  } hga_result_t;

  function automatic hga_result_t make_result(hga_status_e st, logic [11:0] idx,
                                              hga_entry_t e);
    hga_result_t r;
    r.status             = st;
    r.entry_index        = idx;
    r.group_pc           = e.pc;
    r.group_opcode_hash  = e.op_sig;
    r.group_attrs        = e.attrs;
    r.group_count        = e.count;
    r.group_first_seq    = e.start_seq;
    r.group_first_frame  = e.start_frame;
    r.group_last_frame   = e.latest_frame;
    r.group_sample_raw   = e.raw_sample;
    r.group_sample_value = e.value_sample;
    r.group_slot_span    = {e.slot_lo, e.slot_hi};
    return r;
  endfunction

endpackage

// ===== src/hga_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hga_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/hga_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transfers, computes the key hash and classifies
// each request before it enters the command queue. Depends on hga_pkg.
module hga_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [63:0]       seq,
  input  logic [31:0]       frame,
  input  logic [31:0]       pc,
  input  logic [31:0]       op_sig,
  input  logic [31:0]       raw,
  input  logic [31:0]       value,
  input  logic [15:0]       slot,
  input  logic [7:0]        cpu,
  input  logic [7:0]        flags,
  input  logic [7:0]        width,
  input  logic [11:0]       read_index,
  input  logic              q_full,
  output logic              q_push,
  output hga_pkg::hga_cmd_t q_cmd
);
  import hga_pkg::*;

  logic        f_valid;
  hga_cmd_t    f_cmd;
  logic [31:0] f_prod;
  logic [31:0] prod_c;
  logic        accept;
  hga_kind_e   kind_c;

  assign prod_c   = pc * HASH_MULT;
  assign q_push   = f_valid && !q_full;
  assign in_stall = hold || (f_valid && !q_push);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (req_type) begin
      kind_c = CMD_READ;
    end else if (flags[SKIP_BIT]) begin
      kind_c = CMD_SKIP;
    end else begin
      kind_c = CMD_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_prod           <= prod_c;
      f_cmd.kind       <= kind_c;
      f_cmd.seq        <= seq;
      f_cmd.frame      <= frame;
      f_cmd.pc         <= pc;
      f_cmd.op_sig     <= op_sig;
      f_cmd.raw        <= raw;
      f_cmd.value      <= value;
      f_cmd.slot       <= slot;
      f_cmd.attrs      <= {cpu, flags, width};
      f_cmd.read_index <= read_index;
      f_cmd.home       <= {cpu, 24'd0} ^ {12'd0, flags, 12'd0} ^ {24'd0, width};
    end
  end

  // attrs-derived terms were parked in home; fold in product and opcode hash
  always_comb begin
    q_cmd      = f_cmd;
    q_cmd.home = f_prod ^ f_cmd.op_sig ^ f_cmd.home;
  end

endmodule

// ===== src/hga_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on hga_pkg.
module hga_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hga_pkg::hga_cmd_t push_cmd,
  input  logic              pop,
  output hga_pkg::hga_cmd_t head,
  output logic              empty,
  output logic              full
);
  import hga_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  hga_cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("command queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
`endif

endmodule

// ===== src/hga_back.sv =====
`timescale 1ns / 1ps
// Back end: clears the used marks after reset, probes the group table,
// updates entries and holds the result register. Depends on hga_pkg, hga_ram.
module hga_back #(
  parameter int unsigned TABLE_DEPTH = hga_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hga_pkg::hga_cmd_t    q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hga_pkg::hga_result_t out_res
);
  import hga_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = $bits(hga_entry_t);

  hga_state_e  state, state_next;
  logic [IDX_W-1:0] clr_idx, clr_idx_next;
  logic [IDX_W-1:0] probe_idx, probe_idx_next;
  logic [IDX_W-1:0] probe_cnt, probe_cnt_next;
  hga_cmd_t    cur, cur_next;
  hga_result_t res_next;
  logic        load;
  logic        can_load;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  hga_entry_t       wdata, rdata, upd, fresh;
  logic             hit;

  hga_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign can_load = !out_valid || !out_stall;
  assign clearing = (state == ST_CLEAR);
  assign hit = rdata.used && (rdata.pc == cur.pc) && (rdata.op_sig == cur.op_sig)
               && (rdata.attrs == cur.attrs);

  always_comb begin
    fresh              = '0;
    fresh.used         = 1'b1;
    fresh.pc           = cur.pc;
    fresh.op_sig       = cur.op_sig;
    fresh.attrs        = cur.attrs;
    fresh.count        = 64'd1;
    fresh.start_seq    = cur.seq;
    fresh.start_frame  = cur.frame;
    fresh.latest_frame = cur.frame;
    fresh.raw_sample   = cur.raw;
    fresh.value_sample = cur.value;
    fresh.slot_lo      = cur.slot;
    fresh.slot_hi      = cur.slot;

    upd              = rdata;
    upd.count        = rdata.count + 64'd1;
    upd.latest_frame = cur.frame;
    if (cur.slot < rdata.slot_lo) begin
      upd.slot_lo = cur.slot;
    end
    if (cur.slot > rdata.slot_hi) begin
      upd.slot_hi = cur.slot;
    end
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    probe_idx_next = probe_idx;
    probe_cnt_next = probe_cnt;
    cur_next       = cur;
    res_next       = make_result(STAT_SKIP, 12'd0, '0);
    load           = 1'b0;
    q_pop          = 1'b0;
    we             = 1'b0;
    waddr          = probe_idx;
    wdata          = fresh;
    re             = 1'b0;
    raddr          = probe_idx;
    case (state)
      ST_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_idx;
        wdata        = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            CMD_SKIP: begin
              if (can_load) begin
                q_pop = 1'b1;
                load  = 1'b1;
              end
            end
            CMD_READ: begin
              if (32'(q_head.read_index) >= 32'(TABLE_DEPTH)) begin
                if (can_load) begin
                  q_pop    = 1'b1;
                  load     = 1'b1;
                  res_next = make_result(STAT_RD_EMPTY, q_head.read_index, '0);
                end
              end else begin
                q_pop      = 1'b1;
                re         = 1'b1;
                raddr      = IDX_W'(q_head.read_index);
                cur_next   = q_head;
                state_next = ST_CHECK;
              end
            end
            default: begin
              q_pop          = 1'b1;
              re             = 1'b1;
              raddr          = IDX_W'(q_head.home);
              probe_idx_next = IDX_W'(q_head.home);
              probe_cnt_next = '0;
              cur_next       = q_head;
              state_next     = ST_CHECK;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (cur.kind == CMD_READ) begin
          if (can_load) begin
            load       = 1'b1;
            state_next = ST_IDLE;
            if (rdata.used) begin
              res_next = make_result(STAT_RD_USED, cur.read_index, rdata);
            end else begin
              res_next = make_result(STAT_RD_EMPTY, cur.read_index, '0);
            end
          end
        end else if (!rdata.used) begin
          if (can_load) begin
            we         = 1'b1;
            wdata      = fresh;
            load       = 1'b1;
            res_next   = make_result(STAT_NEW, 12'(probe_idx), fresh);
            state_next = ST_IDLE;
          end
        end else if (hit) begin
          if (can_load) begin
            we         = 1'b1;
            wdata      = upd;
            load       = 1'b1;
            res_next   = make_result(STAT_HIT, 12'(probe_idx), upd);
            state_next = ST_IDLE;
          end
        end else if (probe_cnt == '1) begin
          if (can_load) begin
            load       = 1'b1;
            res_next   = make_result(STAT_FULL, 12'd0, '0);
            state_next = ST_IDLE;
          end
        end else begin
          re             = 1'b1;
          raddr          = probe_idx + 1'b1;
          probe_idx_next = probe_idx + 1'b1;
          probe_cnt_next = probe_cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    probe_idx <= probe_idx_next;
    probe_cnt <= probe_cnt_next;
    cur       <= cur_next;
    if (load) begin
      out_res <= res_next;
    end
  end

`ifndef SYNTH
  a_clear_no_used: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !(we && wdata.used))
    else $error("used mark set during clearing pass");
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && $past(state) != ST_CHECK) |-> $past(re))
    else $error("probe check without table read");
  a_update_writes: assert property (@(posedge clk) disable iff (rst)
    (load && (res_next.status == STAT_NEW || res_next.status == STAT_HIT)) |-> we)
    else $error("group result without table write");
  a_no_pop_in_check: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("queue popped while busy");
`endif

endmodule

// ===== src/hash_group_aggregator_core.sv =====
`timescale 1ns / 1ps
// Hash group aggregator: linear-probing group-by table over trace records.
// Input channel in_valid/in_stall, result channel out_valid/out_stall;
// each field is its own port. One result per request.
// req_type 0 inserts a record (skipped when flags bit 4 is set), 1 reads
// table entry read_index.
// The table has one read and one write port; the probe engine serves one
// request at a time. An in-range read reads its entry and then checks it;
// an insert reads its home entry, then probes entry after entry until it
// finds a free or matching one or has probed the whole table; a skipped
// record or an out-of-range read is answered from the idle state.
// A two-entry command queue separates hashing from probing, so the front
// keeps taking transfers while a result waits in the output register.
// Reset: the used marks are cleared by a pass over all TABLE_DEPTH entries,
// one entry a cycle; in_stall stays high until it finishes.
// When the receiver holds out_stall, the result register keeps its value,
// the probe engine waits and the queue fills, then in_stall rises.
module hash_group_aggregator_core #(
  parameter int unsigned TABLE_DEPTH = hga_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] seq,
  input  logic [31:0] frame,
  input  logic [31:0] pc,
  input  logic [31:0] op_sig,
  input  logic [31:0] raw,
  input  logic [31:0] value,
  input  logic [15:0] slot,
  input  logic [7:0]  cpu,
  input  logic [7:0]  flags,
  input  logic [7:0]  width,
  input  logic [11:0] read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [11:0] entry_index,
  output logic [31:0] group_pc,
  output logic [31:0] group_opcode_hash,
  output logic [23:0] group_attrs,
  output logic [63:0] group_count,
  output logic [63:0] group_first_seq,
  output logic [31:0] group_first_frame,
  output logic [31:0] group_last_frame,
  output logic [31:0] group_sample_raw,
  output logic [31:0] group_sample_value,
  output logic [31:0] group_slot_span
);
  import hga_pkg::*;

  hga_cmd_t    push_cmd, head;
  logic        push, pop, q_empty, q_full, clearing;
  hga_result_t res;

  hga_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .seq        (seq),
    .frame      (frame),
    .pc         (pc),
    .op_sig     (op_sig),
    .raw        (raw),
    .value      (value),
    .slot       (slot),
    .cpu        (cpu),
    .flags      (flags),
    .width      (width),
    .read_index (read_index),
    .q_full     (q_full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  hga_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  hga_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (head),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  assign status             = res.status;
  assign entry_index        = res.entry_index;
  assign group_pc           = res.group_pc;
  assign group_opcode_hash  = res.group_opcode_hash;
  assign group_attrs        = res.group_attrs;
  assign group_count        = res.group_count;
  assign group_first_seq    = res.group_first_seq;
  assign group_first_frame  = res.group_first_frame;
  assign group_last_frame   = res.group_last_frame;
  assign group_sample_raw   = res.group_sample_raw;
  assign group_sample_value = res.group_sample_value;
  assign group_slot_span    = res.group_slot_span;

endmodule

// ===== test/hash_group_aggregator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hash_group_aggregator_core: predicts each result
// of the group table in-bench and compares field by field. Needs hga_pkg.
module hash_group_aggregator_core_test;
  import hga_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [63:0] seq = '0;
  logic [31:0] frame = '0, pc = '0, op_sig = '0, raw = '0, value = '0;
  logic [15:0] slot = '0;
  logic [7:0]  cpu = '0, flags = '0, width = '0;
  logic [11:0] read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [11:0] entry_index;
  logic [31:0] group_pc, group_opcode_hash;
  logic [23:0] group_attrs;
  logic [63:0] group_count, group_first_seq;
  logic [31:0] group_first_frame, group_last_frame, group_sample_raw;
  logic [31:0] group_sample_value, group_slot_span;

  hash_group_aggregator_core u_top (.*);

  always #5 clk = ~clk;

  // Predicted table contents
  hga_entry_t  groups [DEPTH];
  hga_result_t pending_results [$];
  int          fail_count = 0;
  int          result_count = 0;
  int          sent_count = 0;
  int          idle_pct = 22;
  int          hold_cycles = 0;

  function automatic hga_result_t entry_view(hga_status_e st, logic [11:0] idx);
    hga_result_t r;
    r = '0;
    r.status             = st;
    r.entry_index        = idx;
    r.group_pc           = groups[idx].pc;
    r.group_opcode_hash  = groups[idx].op_sig;
    r.group_attrs        = groups[idx].attrs;
    r.group_count        = groups[idx].count;
    r.group_first_seq    = groups[idx].start_seq;
    r.group_first_frame  = groups[idx].start_frame;
    r.group_last_frame   = groups[idx].latest_frame;
    r.group_sample_raw   = groups[idx].raw_sample;
    r.group_sample_value = groups[idx].value_sample;
    r.group_slot_span    = {groups[idx].slot_lo, groups[idx].slot_hi};
    return r;
  endfunction

  function automatic hga_result_t aggregate(logic rq, logic [63:0] s, logic [31:0] f,
      logic [31:0] p, logic [31:0] oh, logic [31:0] rw, logic [31:0] v, logic [15:0] sl,
      logic [7:0] c, logic [7:0] fl, logic [7:0] w, logic [11:0] ri);
    hga_result_t r;
    logic [31:0] h;
    logic [23:0] attrs;
    r = '0;
    if (rq == REQ_READ) begin
      if (groups[ri].used) return entry_view(STAT_RD_USED, ri);
      r.status = STAT_RD_EMPTY;
      r.entry_index = ri;
      return r;
    end
    if (fl[SKIP_BIT]) begin
      r.status = STAT_SKIP;
      return r;
    end
    attrs = {c, fl, w};
    h = (p * HASH_MULT) ^ oh ^ (32'(c) << CPU_SHIFT) ^ (32'(fl) << FLAGS_SHIFT) ^ 32'(w);
    h = h & (DEPTH - 1);
    for (int i = 0; i < DEPTH; i++) begin
      if (!groups[h].used) begin
        groups[h] = '{1'b1, p, oh, attrs, 64'd1, s, f, f, rw, v, sl, sl};
        return entry_view(STAT_NEW, h[11:0]);
      end
      if (groups[h].pc == p && groups[h].op_sig == oh && groups[h].attrs == attrs) begin
        groups[h].count++;
        groups[h].latest_frame = f;
        if (sl < groups[h].slot_lo) groups[h].slot_lo = sl;
        if (sl > groups[h].slot_hi) groups[h].slot_hi = sl;
        return entry_view(STAT_HIT, h[11:0]);
      end
      h = (h + 1) & (DEPTH - 1);
    end
    r.status = STAT_FULL;
    return r;
  endfunction

  // in_valid stays high after a transfer; the next call may idle it, wait_drained drops it
  task automatic send_record(logic rq, logic [63:0] s, logic [31:0] f, logic [31:0] p,
      logic [31:0] oh, logic [31:0] rw, logic [31:0] v, logic [15:0] sl, logic [7:0] c,
      logic [7:0] fl, logic [7:0] w, logic [11:0] ri);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq; seq <= s; frame <= f; pc <= p; op_sig <= oh; raw <= rw;
    value <= v; slot <= sl; cpu <= c; flags <= fl; width <= w; read_index <= ri;
    pending_results.push_back(aggregate(rq, s, f, p, oh, rw, v, sl, c, fl, w, ri));
    sent_count++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_insert(logic [31:0] p, logic [31:0] oh, logic [7:0] c,
      logic [7:0] fl, logic [7:0] w);
    send_record(REQ_INSERT, {$urandom, $urandom}, $urandom, p, oh, $urandom, $urandom,
                16'($urandom), c, fl, w, 12'($urandom));
  endtask

  task automatic send_read(logic [11:0] ri);
    send_record(REQ_READ, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom,
                $urandom, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), ri);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Field extremes, skip flag, first hits, reads of used and empty entries
  task automatic test_directed();
    send_record(REQ_INSERT, '1, '1, '1, '1, '1, '1, 16'hffff, 8'hff, 8'hef, 8'hff, '1);
    send_record(REQ_INSERT, '0, '0, '1, '1, '0, '0, 16'h0000, 8'hff, 8'hef, 8'hff, '0);
    send_record(REQ_INSERT, '0, '0, '0, '0, '0, '0, 16'h0000, 8'h00, 8'h00, 8'h00, '0);
    send_record(REQ_INSERT, 64'd5, 32'd7, '0, '0, 32'd1, 32'd2, 16'h8000, 8'h00,
                8'h00, 8'h00, '0);
    send_record(REQ_INSERT, 64'd9, 32'd1, 32'd3, 32'd4, 32'd1, 32'd2, 16'h1, 8'h01,
                8'h10, 8'h02, '0);
    send_record(REQ_INSERT, 64'd9, 32'd1, 32'd3, 32'd4, 32'd1, 32'd2, 16'h1, 8'h01,
                8'hff, 8'h02, '0);
    // same home, different key: forces a probe step
    send_insert(32'd0, 32'd1, 8'h00, 8'h00, 8'h01);
    send_insert(32'd0, 32'd0, 8'h00, 8'h00, 8'h01);
    send_insert(32'd0, 32'd1, 8'h00, 8'h00, 8'h01);
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'hfff);
    send_read(12'h555);
    send_read(12'haaa);
    wait_drained();
  endtask

  // Small key pool so most inserts hit and probe chains form
  task automatic test_random(int n, int pct);
    logic [31:0] key_pc [16];
    logic [31:0] key_oh [16];
    logic [7:0]  key_c [16];
    int k;
    for (int i = 0; i < 16; i++) begin
      key_pc[i] = $urandom; key_oh[i] = $urandom; key_c[i] = 8'($urandom);
    end
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(15);
      case ($urandom_range(9))
        0, 1: send_read(12'($urandom));
        2: send_insert($urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
        3: send_insert(32'd0, 32'($urandom_range(7)), 8'h00, 8'h00, 8'h00);
        default: send_insert(key_pc[k], key_oh[k], key_c[k], 8'(8'h02 | (k & 8'h11)),
                             8'(k));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    test_random(40, 0);
    idle_pct = 22;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    hga_result_t exp;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $error("result with none expected, status %0d", status);
        fail_count++;
      end else begin
        exp = pending_results.pop_front();
        if (status != exp.status) begin
          $error("status exp %0d got %0d", exp.status, status); fail_count++;
        end
        if (entry_index != exp.entry_index) begin
          $error("entry_index exp %0h got %0h", exp.entry_index, entry_index);
          fail_count++;
        end
        if (group_pc != exp.group_pc) begin
          $error("group_pc exp %0h got %0h", exp.group_pc, group_pc); fail_count++;
        end
        if (group_opcode_hash != exp.group_opcode_hash) begin
          $error("group_opcode_hash exp %0h got %0h", exp.group_opcode_hash,
                 group_opcode_hash);
          fail_count++;
        end
        if (group_attrs != exp.group_attrs) begin
          $error("group_attrs exp %0h got %0h", exp.group_attrs, group_attrs);
          fail_count++;
        end
        if (group_count != exp.group_count) begin
          $error("group_count exp %0h got %0h", exp.group_count, group_count);
          fail_count++;
        end
        if (group_first_seq != exp.group_first_seq) begin
          $error("group_first_seq exp %0h got %0h", exp.group_first_seq, group_first_seq);
          fail_count++;
        end
        if (group_first_frame != exp.group_first_frame) begin
          $error("group_first_frame exp %0h got %0h", exp.group_first_frame,
                 group_first_frame);
          fail_count++;
        end
        if (group_last_frame != exp.group_last_frame) begin
          $error("group_last_frame exp %0h got %0h", exp.group_last_frame,
                 group_last_frame);
          fail_count++;
        end
        if (group_sample_raw != exp.group_sample_raw) begin
          $error("group_sample_raw exp %0h got %0h", exp.group_sample_raw,
                 group_sample_raw);
          fail_count++;
        end
        if (group_sample_value != exp.group_sample_value) begin
          $error("group_sample_value exp %0h got %0h", exp.group_sample_value,
                 group_sample_value);
          fail_count++;
        end
        if (group_slot_span != exp.group_slot_span) begin
          $error("group_slot_span exp %0h got %0h", exp.group_slot_span,
                 group_slot_span);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) groups[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500, 22);
    test_random(200, 0);
    test_backpressure();
    test_random(400, 22);
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d records and reads, checked %0d results,", sent_count, result_count);
    $display("covering new groups, hits, skips, probe chains and stalls.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/hga_pkg.sv
src/hga_ram.sv
src/hga_front.sv
src/hga_fifo.sv
src/hga_back.sv
src/hash_group_aggregator_core.sv
test/hash_group_aggregator_core_test.sv
